### hw/rtl/frgcd_pkg.sv
// frgcd_pkg: state type for the fraction reduction block.
// No dependencies; imported by fraction_reduce_gcd.
`timescale 1ns / 1ps

package frgcd_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_GCD,
      ST_DIV_NUM,
      ST_DIV_DEN,
      ST_FINISH
   } state_type;

endpackage

### hw/rtl/frgcd_if.sv
// frgcd_req_if / frgcd_rsp_if: valid/ready channels of the fraction reduction block.
// Depends on nothing; used by fraction_reduce_gcd.
`timescale 1ns / 1ps

interface frgcd_req_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] numerator;
   logic [DATA_WIDTH-1:0] denominator;

   modport source (output valid, output numerator, output denominator, input ready);
   modport sink   (input valid, input numerator, input denominator, output ready);
endinterface

interface frgcd_rsp_if #(
   parameter int DATA_WIDTH = 32
);
   logic                  valid;
   logic                  ready;
   logic [DATA_WIDTH-1:0] gcd_value;
   logic [DATA_WIDTH-1:0] reduced_numerator;
   logic [DATA_WIDTH-1:0] reduced_denominator;
   logic                  invalid;

   modport source (output valid, output gcd_value, output reduced_numerator,
                   output reduced_denominator, output invalid, input ready);
   modport sink   (input valid, input gcd_value, input reduced_numerator,
                   input reduced_denominator, input invalid, output ready);
endinterface

### hw/rtl/fraction_reduce_gcd.sv
// fraction_reduce_gcd: reduces an unsigned fraction to lowest terms and reports the gcd.
// Depends on frgcd_pkg and the channel interfaces in frgcd_if.sv.
`timescale 1ns / 1ps

// One word at a time: the block takes a word only when idle. The gcd comes from a
// binary (shift/subtract) search, in which each step but the last shortens at least one
// operand by a bit; then numerator and denominator are divided by the gcd one quotient
// bit per cycle; the finish state then hands the word to the output register once that
// register is free. A zero numerator or denominator skips the search and the division
// and goes straight to the finish state. One shared subtractor does all the subtract
// work of the search and the division. The result register frees the input side while
// a word waits on rsp.

module fraction_reduce_gcd
   import frgcd_pkg::*;
#(
   parameter int DATA_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   frgcd_req_if.sink   req_ch,
   frgcd_rsp_if.source rsp_ch
);

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);

   state_type state_ff, state_in;

   logic [W-1:0]  num_ff, num_in;
   logic [W-1:0]  den_ff, den_in;
   logic [W-1:0]  a_ff, a_in;
   logic [W-1:0]  b_ff, b_in;
   logic [CW-1:0] k_ff, k_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic [W-1:0]  rem_ff, rem_in;
   logic [W-1:0]  q_ff, q_in;
   logic [W-1:0]  g_ff, g_in;
   logic [W-1:0]  qn_ff, qn_in;
   logic          inv_ff, inv_in;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [W-1:0]  rsp_gcd_ff, rsp_num_ff, rsp_den_ff;
   logic          rsp_inv_ff;

   logic          req_fire;
   logic          out_free;
   logic          load_out;
   logic          req_ready;

   logic [W:0]    sub_a, sub_b;
   logic [W+1:0]  diff;
   logic          borrow;
   logic [W-1:0]  abs_diff;
   logic          gcd_eq;
   logic          cnt_last;
   logic [W-1:0]  q_step;
   logic [W-1:0]  rem_step;

   assign req_fire = req_ch.valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ch.ready;
   assign gcd_eq   = (a_ff == b_ff);
   assign cnt_last = (cnt_ff == CW'(W - 1));

   // shared subtractor
   always_comb begin
      if (state_ff == ST_GCD) begin
         sub_a = {1'b0, a_ff};
         sub_b = {1'b0, b_ff};
      end else begin
         sub_a = {rem_ff, q_ff[W-1]};
         sub_b = {1'b0, g_ff};
      end
   end

   assign diff     = {1'b0, sub_a} - {1'b0, sub_b};
   assign borrow   = diff[W+1];
   assign abs_diff = borrow ? (~diff[W-1:0] + W'(1)) : diff[W-1:0];
   assign q_step   = {q_ff[W-2:0], ~borrow};
   assign rem_step = borrow ? sub_a[W-1:0] : diff[W-1:0];

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               if (req_ch.denominator == '0 || req_ch.numerator == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_GCD;
               end
            end
         end
         ST_GCD: begin
            if (gcd_eq) begin
               state_in = ST_DIV_NUM;
            end
         end
         ST_DIV_NUM: begin
            if (cnt_last) begin
               state_in = ST_DIV_DEN;
            end
         end
         ST_DIV_DEN: begin
            if (cnt_last) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      load_out  = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_FINISH: load_out  = out_free;
         default: begin
            req_ready = 1'b0;
            load_out  = 1'b0;
         end
      endcase
   end

   // datapath
   always_comb begin
      num_in = num_ff;
      den_in = den_ff;
      a_in   = a_ff;
      b_in   = b_ff;
      k_in   = k_ff;
      cnt_in = cnt_ff;
      rem_in = rem_ff;
      q_in   = q_ff;
      g_in   = g_ff;
      qn_in  = qn_ff;
      inv_in = inv_ff;
      case (state_ff)
         ST_IDLE: begin
            num_in = req_ch.numerator;
            den_in = req_ch.denominator;
            a_in   = req_ch.numerator;
            b_in   = req_ch.denominator;
            k_in   = '0;
            cnt_in = '0;
            rem_in = '0;
            inv_in = (req_ch.denominator == '0);
            if (req_ch.denominator == '0) begin
               g_in  = '0;
               qn_in = req_ch.numerator;
               q_in  = '0;
            end else begin
               g_in  = req_ch.denominator;
               qn_in = '0;
               q_in  = W'(1);
            end
         end
         ST_GCD: begin
            if (gcd_eq) begin
               g_in   = a_ff << k_ff;
               q_in   = num_ff;
               rem_in = '0;
               cnt_in = '0;
            end else if (!a_ff[0] && !b_ff[0]) begin
               a_in = a_ff >> 1;
               b_in = b_ff >> 1;
               k_in = k_ff + CW'(1);
            end else if (!a_ff[0]) begin
               a_in = a_ff >> 1;
            end else if (!b_ff[0]) begin
               b_in = b_ff >> 1;
            end else if (borrow) begin
               b_in = abs_diff >> 1;
            end else begin
               a_in = abs_diff >> 1;
            end
         end
         ST_DIV_NUM: begin
            q_in   = q_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CW'(1);
            if (cnt_last) begin
               qn_in  = q_step;
               q_in   = den_ff;
               rem_in = '0;
               cnt_in = '0;
            end
         end
         ST_DIV_DEN: begin
            q_in   = q_step;
            rem_in = rem_step;
            cnt_in = cnt_ff + CW'(1);
         end
         default: begin
            q_in = q_ff;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load_out) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      num_ff <= num_in;
      den_ff <= den_in;
      a_ff   <= a_in;
      b_ff   <= b_in;
      k_ff   <= k_in;
      cnt_ff <= cnt_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      g_ff   <= g_in;
      qn_ff  <= qn_in;
      inv_ff <= inv_in;
      if (load_out) begin
         rsp_gcd_ff <= g_ff;
         rsp_num_ff <= qn_ff;
         rsp_den_ff <= q_ff;
         rsp_inv_ff <= inv_ff;
      end
   end

   assign req_ch.ready               = req_ready;
   assign rsp_ch.valid               = rsp_valid_ff;
   assign rsp_ch.gcd_value           = rsp_gcd_ff;
   assign rsp_ch.reduced_numerator   = rsp_num_ff;
   assign rsp_ch.reduced_denominator = rsp_den_ff;
   assign rsp_ch.invalid             = rsp_inv_ff;

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_inv_ff |-> rsp_gcd_ff == '0 && rsp_den_ff == '0)
      else $error("invalid word with nonzero gcd or denominator");

   a_valid_gcd: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_inv_ff |-> rsp_gcd_ff != '0 && rsp_den_ff != '0)
      else $error("valid word with zero gcd or denominator");

   a_gcd_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_GCD |-> a_ff != '0 && b_ff != '0)
      else $error("gcd operand reached zero");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE && !req_ch.ready)
      else $error("block stayed idle after accepting a word");

endmodule

### tb/testbench.sv
// testbench: self-checking bench for fraction_reduce_gcd over its req/rsp valid/ready channels.
// Depends on frgcd_pkg, frgcd_req_if/frgcd_rsp_if (frgcd_if.sv) and fraction_reduce_gcd.
`timescale 1ns / 1ps

module testbench;

   localparam int DW = 32;
   localparam logic [DW-1:0] ALL_ONES = '1;
   localparam logic [DW-1:0] TOP_BIT  = 32'h8000_0000;
   localparam int RANDOM_PER_PHASE = 420;
   localparam int LONG_HOLD = 600;
   localparam int DRAIN_LIMIT = 20000;
   localparam int SETTLE_CYCLES = 300;

   typedef struct packed {
      logic [DW-1:0] gcd_value;
      logic [DW-1:0] reduced_numerator;
      logic [DW-1:0] reduced_denominator;
      logic          invalid;
   } fraction_type;

   typedef struct packed {
      logic [DW-1:0] numerator;
      logic [DW-1:0] denominator;
      logic          typed;
      fraction_type  want;
   } vector_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   frgcd_req_if #(.DATA_WIDTH(DW)) req_bus ();
   frgcd_rsp_if #(.DATA_WIDTH(DW)) rsp_bus ();

   fraction_reduce_gcd #(.DATA_WIDTH(DW)) dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   always #1 clock = ~clock;

   fraction_type pending_fractions[$];
   vector_type   directed_tbl[$];
   int unsigned sender_idle_pct   = 0;
   int unsigned receiver_stall_pct = 0;
   bit          hold_start = 1'b0;
   int unsigned words_sent = 0;
   int unsigned words_checked = 0;
   int unsigned mismatch_count = 0;
   int unsigned input_stall_cycles = 0;
   int unsigned invalid_seen = 0;

   function automatic fraction_type reduce_fraction(input logic [DW-1:0] num,
                                                    input logic [DW-1:0] den);
      logic [DW-1:0] x;
      logic [DW-1:0] y;
      logic [DW-1:0] r;
      fraction_type  f;
      if (den == '0) begin
         f = '{gcd_value: '0, reduced_numerator: num, reduced_denominator: '0, invalid: 1'b1};
      end else if (num == '0) begin
         f = '{gcd_value: den, reduced_numerator: '0, reduced_denominator: DW'(1),
               invalid: 1'b0};
      end else begin
         x = num;
         y = den;
         while (y != '0) begin
            r = x % y;
            x = y;
            y = r;
         end
         f = '{gcd_value: x, reduced_numerator: num / x, reduced_denominator: den / x,
               invalid: 1'b0};
      end
      return f;
   endfunction

   // pick operands: fractions with a shared factor (the largest share), plus raw noise and edge values
   task automatic next_fraction(output logic [DW-1:0] num, output logic [DW-1:0] den);
      logic [DW-1:0] g;
      logic [DW-1:0] a;
      logic [DW-1:0] b;
      int unsigned   pick;
      pick = $urandom_range(99);
      g = $urandom >> $urandom_range(0, 31);
      if (g == '0) g = DW'(1);
      a = ($urandom >> $urandom_range(12, 31)) | 1;
      b = ($urandom >> $urandom_range(12, 31)) | 1;
      if (pick < 40) begin
         num = a * g;
         den = b * g;
      end else if (pick < 60) begin
         num = $urandom;
         den = $urandom;
      end else if (pick < 70) begin
         num = $urandom_range(255);
         den = $urandom_range(255);
      end else if (pick < 78) begin
         num = $urandom << $urandom_range(0, 31);
         den = TOP_BIT >> $urandom_range(0, 31);
      end else if (pick < 84) begin
         num = $urandom;
         den = '0;
      end else if (pick < 90) begin
         num = '0;
         den = $urandom;
      end else if (pick < 95) begin
         num = $urandom;
         den = num;
      end else begin
         num = ($urandom_range(1)) ? ALL_ONES : TOP_BIT;
         den = ($urandom_range(1)) ? ALL_ONES - $urandom_range(3) : g;
      end
   endtask

   task automatic offer_word(input logic [DW-1:0] num, input logic [DW-1:0] den,
                             input fraction_type want);
      while ($urandom_range(99) < sender_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.numerator   <= num;
      req_bus.denominator <= den;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      pending_fractions.push_back(want);
      words_sent++;
   endtask

   // receiver: random stalls, plus one long hold-off on request
   initial begin
      int unsigned hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_start) begin
            hold_start = 1'b0;
            hold_left  = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   always @(posedge clock) begin
      fraction_type want;
      fraction_type got;
      if (!reset) begin
         if (req_bus.valid && !req_bus.ready) input_stall_cycles++;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{gcd_value: rsp_bus.gcd_value,
                    reduced_numerator: rsp_bus.reduced_numerator,
                    reduced_denominator: rsp_bus.reduced_denominator,
                    invalid: rsp_bus.invalid};
            if (pending_fractions.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected word: gcd=%h num=%h den=%h inv=%b",
                           got.gcd_value, got.reduced_numerator,
                           got.reduced_denominator, got.invalid);
            end else begin
               want = pending_fractions.pop_front();
               words_checked++;
               if (got.invalid) invalid_seen++;
               if (got.gcd_value !== want.gcd_value ||
                   got.reduced_numerator !== want.reduced_numerator ||
                   got.reduced_denominator !== want.reduced_denominator ||
                   got.invalid !== want.invalid) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("mismatch word %0d: exp %h/%h/%h/%b got %h/%h/%h/%b",
                              words_checked, want.gcd_value, want.reduced_numerator,
                              want.reduced_denominator, want.invalid, got.gcd_value,
                              got.reduced_numerator, got.reduced_denominator, got.invalid);
               end
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("fraction_reduce_gcd test failed");
      $finish;
   end

   initial begin
      logic [DW-1:0] num;
      logic [DW-1:0] den;
      fraction_type  want;
      int            i;
      int            phase;
      req_bus.valid       <= 1'b0;
      req_bus.numerator   <= '0;
      req_bus.denominator <= '0;

      directed_tbl.push_back('{'0, '0, 1'b1, '{'0, '0, '0, 1'b1}});
      directed_tbl.push_back('{ALL_ONES, '0, 1'b1, '{'0, ALL_ONES, '0, 1'b1}});
      directed_tbl.push_back('{32'd12345, '0, 1'b1, '{'0, 32'd12345, '0, 1'b1}});
      directed_tbl.push_back('{'0, ALL_ONES, 1'b1, '{ALL_ONES, '0, 32'd1, 1'b0}});
      directed_tbl.push_back('{'0, 32'd1, 1'b1, '{32'd1, '0, 32'd1, 1'b0}});
      directed_tbl.push_back('{'0, 32'd77, 1'b1, '{32'd77, '0, 32'd1, 1'b0}});
      directed_tbl.push_back('{32'd1, 32'd1, 1'b1, '{32'd1, 32'd1, 32'd1, 1'b0}});
      directed_tbl.push_back('{ALL_ONES, ALL_ONES, 1'b1, '{ALL_ONES, 32'd1, 32'd1, 1'b0}});
      directed_tbl.push_back('{ALL_ONES, 32'd1, 1'b1, '{32'd1, ALL_ONES, 32'd1, 1'b0}});
      directed_tbl.push_back('{32'd1, ALL_ONES, 1'b1, '{32'd1, 32'd1, ALL_ONES, 1'b0}});
      directed_tbl.push_back('{TOP_BIT, TOP_BIT >> 1, 1'b1,
                               '{TOP_BIT >> 1, 32'd2, 32'd1, 1'b0}});
      directed_tbl.push_back('{TOP_BIT, 32'd1, 1'b1, '{32'd1, TOP_BIT, 32'd1, 1'b0}});
      directed_tbl.push_back('{32'd12, 32'd18, 1'b0, '0});
      directed_tbl.push_back('{32'd18, 32'd12, 1'b0, '0});
      directed_tbl.push_back('{ALL_ONES, ALL_ONES - 1, 1'b0, '0});
      directed_tbl.push_back('{32'hFFFF_FFFE, 32'h7FFF_FFFF, 1'b0, '0});
      directed_tbl.push_back('{32'd832040, 32'd514229, 1'b0, '0});
      directed_tbl.push_back('{32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0});
      directed_tbl.push_back('{32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0});
      directed_tbl.push_back('{32'd48, 32'd180, 1'b0, '0});
      directed_tbl.push_back('{32'd7, 32'd13, 1'b0, '0});
      directed_tbl.push_back('{32'd1000000, 32'd1000, 1'b0, '0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_tbl[k]) begin
         want = directed_tbl[k].typed ? directed_tbl[k].want
                : reduce_fraction(directed_tbl[k].numerator, directed_tbl[k].denominator);
         offer_word(directed_tbl[k].numerator, directed_tbl[k].denominator, want);
      end

      for (phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
            1: begin sender_idle_pct = 76; receiver_stall_pct = 0;  end
            2: begin sender_idle_pct = 0;  receiver_stall_pct = 76; end
            default: begin sender_idle_pct = 38; receiver_stall_pct = 38; end
         endcase
         for (i = 0; i < RANDOM_PER_PHASE; i++) begin
            // hold off rsp while req keeps offering so the block backs up
            if (phase == 0 && i == 20) hold_start = 1'b1;
            next_fraction(num, den);
            offer_word(num, den, reduce_fraction(num, den));
         end
      end
      req_bus.valid <= 1'b0;

      for (i = 0; i < DRAIN_LIMIT && pending_fractions.size() != 0; i++) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_fractions.size() != 0) begin
         mismatch_count++;
         $display("%0d words never came back", pending_fractions.size());
      end

      $display("sent %0d fractions (%0d directed), checked %0d, %0d with zero denominator",
               words_sent, directed_tbl.size(), words_checked, invalid_seen);
      $display("four idle/stall mixes plus a %0d-cycle rsp hold-off; req stalled %0d cycles",
               LONG_HOLD, input_stall_cycles);
      if (mismatch_count == 0) begin
         $display("fraction_reduce_gcd test passed");
      end else begin
         $display("fraction_reduce_gcd test failed");
      end
      $finish;
   end

endmodule
